### sv/tmsp_pkg.sv
// Shared types and constants for the two-motor soft PWM speed controller.
// Used by the channel interfaces and every module of the block.
package tmsp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PERIOD_W   = 16;
    localparam int STEP_W     = 8;
    localparam int COUNT_W    = 17;
    localparam int ON_W       = 15;

    typedef logic [1:0]         func_t;
    typedef logic [1:0]         motor_idx_t;
    typedef logic signed [10:0] value_t;
    typedef logic signed [7:0]  speed_t;
    typedef logic [1:0]         pins_t;

    localparam func_t FUNC_TICK    = 2'd0;
    localparam func_t FUNC_MEASURE = 2'd1;
    localparam func_t FUNC_SET     = 2'd2;
    localparam func_t FUNC_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 8'd10;

    // bit0 = pin a (reverse), bit1 = pin b (forward)
    localparam pins_t PINS_OFF = 2'b00;
    localparam pins_t PINS_REV = 2'b01;
    localparam pins_t PINS_FWD = 2'b10;

    typedef struct packed {
        func_t      func;
        motor_idx_t motor;
        value_t     value;
    } item_t;

    typedef struct packed {
        logic   status;
        logic   left_pin_a;
        logic   left_pin_b;
        logic   right_pin_a;
        logic   right_pin_b;
        speed_t target_readback;
    } result_t;

    // per-motor command, already qualified by the pipeline advance
    typedef struct packed {
        logic   tick;
        logic   measure;
        logic   set_target;
        value_t value;
    } motor_cmd_t;

    // per-motor state as it stands after the current command
    typedef struct packed {
        pins_t  pins;
        speed_t target;
    } motor_obs_t;

endpackage

### sv/tmsp_if.sv
// Valid/ready channel interfaces: command items, result items, config writes.
// Depends on tmsp_pkg.
interface tmsp_item_if import tmsp_pkg::*; ();
    logic       valid;
    logic       ready;
    func_t      func;
    motor_idx_t motor;
    value_t     value;

    modport source (output valid, func, motor, value, input ready);
    modport sink   (input valid, func, motor, value, output ready);
endinterface

interface tmsp_result_if import tmsp_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   status;
    logic   left_pin_a;
    logic   left_pin_b;
    logic   right_pin_a;
    logic   right_pin_b;
    speed_t target_readback;

    modport source (output valid, status, left_pin_a, left_pin_b, right_pin_a,
                    right_pin_b, target_readback, input ready);
    modport sink   (input valid, status, left_pin_a, left_pin_b, right_pin_a,
                    right_pin_b, target_readback, output ready);
endinterface

interface tmsp_cfg_if import tmsp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/tmsp_cfg_regs.sv
// Configuration registers: PWM period and on ticks per drive unit.
// Depends on tmsp_pkg and tmsp_cfg_if.
module tmsp_cfg_regs
    import tmsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    tmsp_cfg_if.sink            cfg,
    output logic [PERIOD_W-1:0] period,
    output logic [STEP_W-1:0]   step
);

    logic [PERIOD_W-1:0] period_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            step_reg   <= STEP_RESET;
        end
        else if (wr)
        begin
            case (cfg.index)
                REG_PERIOD: period_reg <= cfg.data[PERIOD_W-1:0];
                REG_STEP:   step_reg   <= cfg.data[STEP_W-1:0];
                default:    ;
            endcase
        end
    end

    assign period = period_reg;
    assign step   = step_reg;

endmodule

### sv/tmsp_motor.sv
// One motor channel: target, drive level, PWM phase counter and bridge pins.
// Depends on tmsp_pkg.
module tmsp_motor
    import tmsp_pkg::*;
#(
    parameter int SPEED_LIMIT = 100
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  motor_cmd_t          cmd,
    input  logic [PERIOD_W-1:0] period,
    input  logic [STEP_W-1:0]   step,
    output motor_obs_t          obs
);

    localparam logic signed [11:0] LIM_POS = 12'(SPEED_LIMIT);
    localparam logic signed [11:0] LIM_NEG = -12'(SPEED_LIMIT);

    speed_t             target_reg, target_next;
    speed_t             drive_reg, drive_next;
    logic               phase_on_reg, phase_on_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    pins_t              pins_reg, pins_next;

    logic signed [16:0] prod;
    logic [ON_W-1:0]    on_ticks;
    logic [17:0]        cnt_inc;
    logic               off_end;
    logic               on_end;
    logic signed [11:0] diff;
    logic [11:0]        abs_diff;
    logic [10:0]        half;
    logic               same_sign;
    logic signed [11:0] drive_sum;
    logic signed [11:0] drive_sat;

    assign prod     = drive_reg * $signed({1'b0, step});
    assign on_ticks = prod[16] ? ON_W'(-prod) : ON_W'(prod);
    assign cnt_inc  = 18'(count_reg) + 18'd1;
    // off phase ends once count+1 exceeds period-on; kept unsigned by moving on across
    assign off_end  = (cnt_inc + 18'(on_ticks)) > 18'(period);
    assign on_end   = cnt_inc > 18'(on_ticks);

    assign diff      = 12'(target_reg) - 12'(cmd.value);
    assign abs_diff  = diff[11] ? 12'(-diff) : 12'(diff);
    assign half      = abs_diff[11:1];
    assign same_sign = (diff[11] == target_reg[7]);
    assign drive_sum = same_sign ? 12'(drive_reg) + $signed({1'b0, half})
                                 : 12'(drive_reg) - $signed({1'b0, half});

    always_comb
    begin
        if (drive_sum > LIM_POS)
            drive_sat = LIM_POS;
        else if (drive_sum < LIM_NEG)
            drive_sat = LIM_NEG;
        else
            drive_sat = drive_sum;
    end

    always_comb
    begin
        target_next   = target_reg;
        drive_next    = drive_reg;
        phase_on_next = phase_on_reg;
        count_next    = count_reg;
        pins_next     = pins_reg;
        if (cmd.tick)
        begin
            if (!phase_on_reg)
            begin
                pins_next = PINS_OFF;
                if (off_end)
                begin
                    count_next    = '0;
                    phase_on_next = 1'b1;
                end
                else
                begin
                    count_next = cnt_inc[COUNT_W-1:0];
                end
            end
            else
            begin
                // zero target keeps whatever the pins held
                if (target_reg > 8'sd0)
                    pins_next = PINS_FWD;
                else if (target_reg < 8'sd0)
                    pins_next = PINS_REV;
                if (on_end)
                begin
                    count_next    = '0;
                    phase_on_next = 1'b0;
                end
                else
                begin
                    count_next = cnt_inc[COUNT_W-1:0];
                end
            end
        end
        else if (cmd.measure)
        begin
            drive_next = 8'(drive_sat);
        end
        else if (cmd.set_target)
        begin
            target_next = 8'(cmd.value);
            drive_next  = 8'(cmd.value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            drive_reg    <= '0;
            phase_on_reg <= 1'b0;
            count_reg    <= '0;
            pins_reg     <= PINS_OFF;
        end
        else
        begin
            target_reg   <= target_next;
            drive_reg    <= drive_next;
            phase_on_reg <= phase_on_next;
            count_reg    <= count_next;
            pins_reg     <= pins_next;
        end
    end

    assign obs.pins   = pins_next;
    assign obs.target = target_next;

endmodule

### sv/two_motor_soft_pwm_speed_ctrl.sv
// Two-motor H-bridge soft PWM speed controller, top level.
// Items pass the input register, then the result register, and wait in either while
// results stall. Throughput: one item per cycle while results are accepted; motor
// state updates in the same cycle the item moves from the input register into the
// result register. Reset: period 1000, step 10, all motors off with zero target and
// drive, pipeline empty. Depends on tmsp_pkg, tmsp_if, tmsp_cfg_regs, tmsp_motor.
module two_motor_soft_pwm_speed_ctrl
    import tmsp_pkg::*;
#(
    parameter int NUM_MOTORS  = 2,
    parameter int SPEED_LIMIT = 100
)
(
    input  logic           clk,
    input  logic           rst_n,
    tmsp_item_if.sink      item_in,
    tmsp_result_if.source  result_out,
    tmsp_cfg_if.sink       cfg
);

    localparam logic signed [10:0] LIM_POS = 11'(SPEED_LIMIT);
    localparam logic signed [10:0] LIM_NEG = -11'(SPEED_LIMIT);

    logic                in_valid_reg;
    item_t               in_item_reg;
    logic                out_valid_reg;
    result_t             out_item_reg;
    logic                advance;
    logic                motor_ok;
    logic                in_range;
    logic                status;
    speed_t              readback;
    logic [PERIOD_W-1:0] period;
    logic [STEP_W-1:0]   step;
    motor_cmd_t          cmd   [NUM_MOTORS];
    motor_obs_t          obs   [NUM_MOTORS];
    result_t             res;

    tmsp_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .period (period),
        .step   (step)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_in.ready)
            in_valid_reg <= item_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            in_item_reg.func  <= item_in.func;
            in_item_reg.motor <= item_in.motor;
            in_item_reg.value <= item_in.value;
        end
    end

    assign motor_ok = {1'b0, in_item_reg.motor} < 3'(NUM_MOTORS);
    assign in_range = (in_item_reg.value >= LIM_NEG) && (in_item_reg.value <= LIM_POS);

    genvar g;
    generate
        for (g = 0; g < NUM_MOTORS; g++)
        begin : g_motor
            logic hit;
            assign hit = in_item_reg.motor == motor_idx_t'(g);
            assign cmd[g].tick       = advance && in_item_reg.func == FUNC_TICK;
            assign cmd[g].measure    = advance && in_item_reg.func == FUNC_MEASURE && hit;
            assign cmd[g].set_target = advance && in_item_reg.func == FUNC_SET && hit
                                       && in_range;
            assign cmd[g].value      = in_item_reg.value;

            tmsp_motor #(
                .SPEED_LIMIT (SPEED_LIMIT)
            ) u_motor (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (cmd[g]),
                .period (period),
                .step   (step),
                .obs    (obs[g])
            );
        end
    endgenerate

    always_comb
    begin
        case (in_item_reg.func)
            FUNC_TICK:    status = 1'b0;
            FUNC_MEASURE: status = !motor_ok;
            FUNC_SET:     status = !motor_ok || !in_range;
            default:      status = 1'b1;
        endcase
    end

    always_comb
    begin
        readback = '0;
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            if (in_item_reg.motor == motor_idx_t'(i))
                readback = obs[i].target;
        end
    end

    assign res.status          = status;
    assign res.left_pin_a      = obs[0].pins[0];
    assign res.left_pin_b      = obs[0].pins[1];
    assign res.target_readback = readback;

    generate
        if (NUM_MOTORS > 1)
        begin : g_right
            assign res.right_pin_a = obs[1].pins[0];
            assign res.right_pin_b = obs[1].pins[1];
        end
        else
        begin : g_no_right
            assign res.right_pin_a = 1'b0;
            assign res.right_pin_b = 1'b0;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= res;
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.status          = out_item_reg.status;
    assign result_out.left_pin_a      = out_item_reg.left_pin_a;
    assign result_out.left_pin_b      = out_item_reg.left_pin_b;
    assign result_out.right_pin_a     = out_item_reg.right_pin_a;
    assign result_out.right_pin_b     = out_item_reg.right_pin_b;
    assign result_out.target_readback = out_item_reg.target_readback;

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_unused_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.func == FUNC_UNUSED |=> out_item_reg.status)
        else $error("unused function not rejected");

    a_bad_motor_readback: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !motor_ok |=> out_item_reg.target_readback == 8'sd0)
        else $error("readback of missing motor not zero");

    a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_item_reg.left_pin_a && out_item_reg.left_pin_b)
                          && !(out_item_reg.right_pin_a && out_item_reg.right_pin_b))
        else $error("bridge driven both ways");

    a_readback_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.target_readback <= 8'(SPEED_LIMIT)
                          && out_item_reg.target_readback >= -8'(SPEED_LIMIT))
        else $error("stored target beyond speed limit");

endmodule
